### hdl/vpr_pkg.sv
// Shared constants, types and plane decode for the 4D plane rotation unit.
package vpr_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int PLANE_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES  = 4;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int FRAC_BITS_DEFAULT  = 16;

  // sin/cos core runs in Q30
  localparam int Q      = 30;
  localparam int VAL_W  = 30;   // x, x^2 and products scaled back to Q30, all < 1.0
  localparam int TRIG_W = 31;   // Horner terms, up to exactly 1.0
  localparam logic [TRIG_W-1:0] Q_ONE       = TRIG_W'(1) << Q;
  localparam logic [TRIG_W-1:0] HALF_PI_Q30 = 31'd1686629713;

  // Horner divisors, innermost term first
  localparam int N_TERMS = 5;
  localparam int SIN_DIV [N_TERMS] = '{110, 72, 42, 20, 6};
  localparam int COS_DIV [N_TERMS] = '{90, 56, 30, 12, 2};

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_W = 2'd3;

  // plane codes
  localparam logic [PLANE_W-1:0] PLANE_XY = 3'd0;
  localparam logic [PLANE_W-1:0] PLANE_XZ = 3'd1;
  localparam logic [PLANE_W-1:0] PLANE_XW = 3'd2;
  localparam logic [PLANE_W-1:0] PLANE_YZ = 3'd3;
  localparam logic [PLANE_W-1:0] PLANE_YW = 3'd4;
  localparam logic [PLANE_W-1:0] PLANE_ZW = 3'd5;

  // axis codes, also the index into a point
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_W = 2'd3;

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] vpr_point_t;

  // point data that rides along the whole pipe
  typedef struct packed {
    vpr_point_t                pt;
    logic [PLANE_W-1:0]        plane;
    logic signed [COORD_W:0]   da;
    logic signed [COORD_W:0]   db;
  } vpr_carry_t;

  // word passed between the sin/cos cells
  typedef struct packed {
    vpr_carry_t         cry;
    logic [1:0]         quad;
    logic               swap;
    logic [VAL_W-1:0]   x;
    logic [VAL_W-1:0]   x2;
    logic [TRIG_W-1:0]  s;
    logic [TRIG_W-1:0]  c;
  } vpr_poly_t;

  function automatic logic [1:0] axis_lo(input logic [PLANE_W-1:0] pl);
    case (pl)
      PLANE_XY, PLANE_XZ, PLANE_XW: axis_lo = AXIS_X;
      PLANE_YZ, PLANE_YW:           axis_lo = AXIS_Y;
      PLANE_ZW:                     axis_lo = AXIS_Z;
      default:                      axis_lo = AXIS_X;
    endcase
  endfunction

  function automatic logic [1:0] axis_hi(input logic [PLANE_W-1:0] pl);
    case (pl)
      PLANE_XY:                     axis_hi = AXIS_Y;
      PLANE_XZ, PLANE_YZ:           axis_hi = AXIS_Z;
      PLANE_XW, PLANE_YW, PLANE_ZW: axis_hi = AXIS_W;
      default:                      axis_hi = AXIS_Y;
    endcase
  endfunction

  // planes whose rotation runs the other way
  function automatic logic plane_flip(input logic [PLANE_W-1:0] pl);
    case (pl)
      PLANE_XZ, PLANE_YW, PLANE_ZW: plane_flip = 1'b1;
      default:                      plane_flip = 1'b0;
    endcase
  endfunction

  function automatic logic plane_ok(input logic [PLANE_W-1:0] pl);
    plane_ok = (pl <= PLANE_ZW);
  endfunction

endpackage

### hdl/vpr_channels.sv
// Handshake channels of the 4D plane rotation unit: points in, results out, register writes.
interface vpr_point_if import vpr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   in_x;
  logic signed [COORD_W-1:0]   in_y;
  logic signed [COORD_W-1:0]   in_z;
  logic signed [COORD_W-1:0]   in_w;
  logic [ANGLE_W-1:0]          turn_angle;
  logic [PLANE_W-1:0]          plane;

  modport source (output valid, in_x, in_y, in_z, in_w, turn_angle, plane, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_w, turn_angle, plane, output ready);
endinterface

interface vpr_result_if import vpr_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_W-1:0]   out_x;
  logic signed [COORD_W-1:0]   out_y;
  logic signed [COORD_W-1:0]   out_z;
  logic signed [COORD_W-1:0]   out_w;
  logic                        clipped;

  modport source (output valid, out_x, out_y, out_z, out_w, clipped, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, clipped, output ready);
endinterface

interface vpr_cfg_if import vpr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_W-1:0]    index;
  logic [COORD_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/vec4_plane_rotation_unit.sv
// Top level of the 4D plane rotation unit: center registers and the pipeline of cells.
//
// Usage:
//   points  : one word per point (x, y, z, w in signed Q16.16, binary angle, plane code).
//   rotated : one word per point, in order: rotated point and a clipped flag.
//   cfg     : register writes, index 0..3 = center x, y, z, w; always ready.
//             Write only while no point is in flight.
// Pipeline: 25 register stages (3 front stages, five series cells of 3 stages each,
//   3 coefficient stages, 4 mix stages ending in the output register).
// Throughput: one point per cycle while rotated.ready stays high, with every stage
//   fed every cycle.
// Reset (rst, synchronous): clears the centers to zero and all stage valid bits.
// Stall: while rotated.ready is low the result stays in the output register;
//   earlier stages keep moving until they fill, so points are still accepted
//   as long as any stage holds a bubble.
// Plane codes 6 and 7 pass the point through unchanged with clipped low.
module vec4_plane_rotation_unit import vpr_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  vpr_cfg_if.sink       cfg,
  vpr_point_if.sink     points,
  vpr_result_if.source  rotated
);

  // center registers
  vpr_point_t center;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CENTER_X: center[AXIS_X] <= cfg.data;
        REG_CENTER_Y: center[AXIS_Y] <= cfg.data;
        REG_CENTER_Z: center[AXIS_Z] <= cfg.data;
        REG_CENTER_W: center[AXIS_W] <= cfg.data;
        default: ;
      endcase
    end
  end

  // incoming point as an indexable vector
  vpr_point_t pt_in;

  assign pt_in[AXIS_X] = points.in_x;
  assign pt_in[AXIS_Y] = points.in_y;
  assign pt_in[AXIS_Z] = points.in_z;
  assign pt_in[AXIS_W] = points.in_w;

  // chain of series cells; slot 0 is fed by the front stages
  vpr_poly_t          chain       [N_TERMS+1];
  logic [N_TERMS:0]   chain_valid;
  logic [N_TERMS:0]   chain_ready;

  vpr_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .center   (center),
    .up_valid (points.valid),
    .up_ready (points.ready),
    .pt       (pt_in),
    .angle    (points.turn_angle),
    .plane    (points.plane),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn       (chain[0])
  );

  genvar i;
  generate
    for (i = 0; i < N_TERMS; i++) begin : g_term
      vpr_cell #(
        .SDIV (SIN_DIV[i]),
        .CDIV (COS_DIV[i])
      ) u_term (
        .clk      (clk),
        .rst      (rst),
        .up_valid (chain_valid[i]),
        .up_ready (chain_ready[i]),
        .up       (chain[i]),
        .dn_valid (chain_valid[i+1]),
        .dn_ready (chain_ready[i+1]),
        .dn       (chain[i+1])
      );
    end
  endgenerate

  // signed coefficients
  logic                        coef_valid;
  logic                        coef_ready;
  vpr_carry_t                  coef_cry;
  logic signed [FRAC_BITS+1:0] coef_sn;
  logic signed [FRAC_BITS+1:0] coef_cs;

  vpr_coef #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[N_TERMS]),
    .up_ready (chain_ready[N_TERMS]),
    .up       (chain[N_TERMS]),
    .dn_valid (coef_valid),
    .dn_ready (coef_ready),
    .dn_cry   (coef_cry),
    .dn_sn    (coef_sn),
    .dn_cs    (coef_cs)
  );

  // rotate, re-center, saturate; last stage is the output register
  vpr_point_t res_pt;
  logic       res_clip;

  vpr_mix #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mix (
    .clk      (clk),
    .rst      (rst),
    .center   (center),
    .up_valid (coef_valid),
    .up_ready (coef_ready),
    .up_cry   (coef_cry),
    .up_sn    (coef_sn),
    .up_cs    (coef_cs),
    .dn_valid (rotated.valid),
    .dn_ready (rotated.ready),
    .res_pt   (res_pt),
    .res_clip (res_clip)
  );

  assign rotated.out_x   = res_pt[AXIS_X];
  assign rotated.out_y   = res_pt[AXIS_Y];
  assign rotated.out_z   = res_pt[AXIS_Z];
  assign rotated.out_w   = res_pt[AXIS_W];
  assign rotated.clipped = res_clip;

endmodule

### hdl/vpr_front.sv
// Front stages: angle to octant and radians, x^2, and offsets from the center.
module vpr_front import vpr_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vpr_point_t           center,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  vpr_point_t           pt,
  input  logic [ANGLE_W-1:0]   angle,
  input  logic [PLANE_W-1:0]   plane,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output vpr_poly_t            dn
);

  localparam logic [COORD_W-1:0] ANG_MASK = COORD_W'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int TURN_SHIFT = COORD_W - ANGLE_BITS;

  logic [2:0] v;
  logic [2:0] en;

  assign en[2] = ~v[2] | dn_ready;
  assign en[1] = ~v[1] | en[2];
  assign en[0] = ~v[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // stage 0: fold the turn into [0, 1/8] of a circle
  logic [COORD_W-1:0]   turn;
  logic [VAL_W-1:0]     r;
  logic [TRIG_W-1:0]    r_mirror;
  logic [1:0]           lo;
  logic [1:0]           hi;
  vpr_carry_t           cry_n;

  assign turn     = (COORD_W'(angle) & ANG_MASK) << TURN_SHIFT;
  assign r        = turn[VAL_W-1:0];
  assign r_mirror = Q_ONE - TRIG_W'(r);
  assign lo       = axis_lo(plane);
  assign hi       = axis_hi(plane);

  always_comb begin
    cry_n.pt    = pt;
    cry_n.plane = plane;
    cry_n.da    = $signed({pt[lo][COORD_W-1], pt[lo]})
                - $signed({center[lo][COORD_W-1], center[lo]});
    cry_n.db    = $signed({pt[hi][COORD_W-1], pt[hi]})
                - $signed({center[hi][COORD_W-1], center[hi]});
  end

  vpr_carry_t           cry0;
  logic [1:0]           quad0;
  logic                 swap0;
  logic [VAL_W-1:0]     f0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cry0  <= cry_n;
      quad0 <= turn[COORD_W-1:COORD_W-2];
      swap0 <= r[VAL_W-1];
      f0    <= r[VAL_W-1] ? r_mirror[VAL_W-1:0] : r;
    end
  end

  // stage 1: x = f * pi/2 in Q30
  logic [VAL_W+TRIG_W-1:0] px;
  vpr_carry_t              cry1;
  logic [1:0]              quad1;
  logic                    swap1;
  logic [VAL_W-1:0]        x1;

  assign px = f0 * HALF_PI_Q30;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cry1  <= cry0;
      quad1 <= quad0;
      swap1 <= swap0;
      x1    <= px[Q +: VAL_W];
    end
  end

  // stage 2: x^2
  logic [2*VAL_W-1:0] pxx;

  assign pxx = x1 * x1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dn.cry  <= cry1;
      dn.quad <= quad1;
      dn.swap <= swap1;
      dn.x    <= x1;
      dn.x2   <= pxx[Q +: VAL_W];
      dn.s    <= Q_ONE;
      dn.c    <= Q_ONE;
    end
  end

endmodule

### hdl/vpr_cell.sv
// One Horner step of the sine and cosine series: t = 1 - (x^2 * t) / d.
module vpr_cell import vpr_pkg::*; #(
  parameter int SDIV = 6,
  parameter int CDIV = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  vpr_poly_t  up,
  output logic       dn_valid,
  input  logic       dn_ready,
  output vpr_poly_t  dn
);

  // floor(2^32 / d); quotient comes out at most one low
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_SH-1:0] SREC = RECIP_SH'((64'd1 << RECIP_SH) / SDIV);
  localparam logic [RECIP_SH-1:0] CREC = RECIP_SH'((64'd1 << RECIP_SH) / CDIV);
  localparam logic [VAL_W-1:0]    DS   = VAL_W'(SDIV);
  localparam logic [VAL_W-1:0]    DC   = VAL_W'(CDIV);

  logic [2:0] v;
  logic [2:0] en;

  assign en[2] = ~v[2] | dn_ready;
  assign en[1] = ~v[1] | en[2];
  assign en[0] = ~v[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // stage 0: x^2 * term
  logic [VAL_W+TRIG_W-1:0] pms;
  logic [VAL_W+TRIG_W-1:0] pmc;
  vpr_poly_t               w0;
  logic [VAL_W-1:0]        ms0;
  logic [VAL_W-1:0]        mc0;

  assign pms = up.x2 * up.s;
  assign pmc = up.x2 * up.c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w0  <= up;
      ms0 <= pms[Q +: VAL_W];
      mc0 <= pmc[Q +: VAL_W];
    end
  end

  // stage 1: reciprocal multiply
  logic [VAL_W+RECIP_SH-1:0] pqs;
  logic [VAL_W+RECIP_SH-1:0] pqc;
  vpr_poly_t                 w1;
  logic [VAL_W-1:0]          ms1;
  logic [VAL_W-1:0]          mc1;
  logic [VAL_W-1:0]          qs1;
  logic [VAL_W-1:0]          qc1;

  assign pqs = ms0 * SREC;
  assign pqc = mc0 * CREC;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w1  <= w0;
      ms1 <= ms0;
      mc1 <= mc0;
      qs1 <= pqs[RECIP_SH +: VAL_W];
      qc1 <= pqc[RECIP_SH +: VAL_W];
    end
  end

  // stage 2: fix the quotient and form the new term
  logic [VAL_W-1:0]  rem_s;
  logic [VAL_W-1:0]  rem_c;
  logic [TRIG_W-1:0] s_new;
  logic [TRIG_W-1:0] c_new;
  vpr_poly_t         dn_next;

  assign rem_s = ms1 - qs1 * DS;
  assign rem_c = mc1 - qc1 * DC;
  assign s_new = Q_ONE - TRIG_W'(qs1) - TRIG_W'(rem_s >= DS);
  assign c_new = Q_ONE - TRIG_W'(qc1) - TRIG_W'(rem_c >= DC);

  always_comb begin
    dn_next   = w1;
    dn_next.s = s_new;
    dn_next.c = c_new;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dn <= dn_next;
    end
  end

endmodule

### hdl/vpr_coef.sv
// Turns the series results into signed sine and cosine coefficients in Q(FRAC_BITS).
module vpr_coef import vpr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  vpr_poly_t                    up,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output vpr_carry_t                   dn_cry,
  output logic signed [FRAC_BITS+1:0]  dn_sn,
  output logic signed [FRAC_BITS+1:0]  dn_cs
);

  localparam int CW  = FRAC_BITS + 2;
  localparam int MW  = FRAC_BITS + 1;
  localparam int RSH = Q - FRAC_BITS;
  localparam logic [TRIG_W-1:0] RHALF = TRIG_W'(1) << (RSH - 1);

  logic [2:0] v;
  logic [2:0] en;

  assign en[2] = ~v[2] | dn_ready;
  assign en[1] = ~v[1] | en[2];
  assign en[0] = ~v[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  // stage 0: sine = x * series
  logic [VAL_W+TRIG_W-1:0] psn;
  vpr_carry_t              cry0;
  logic [1:0]              quad0;
  logic                    swap0;
  logic [TRIG_W-1:0]       sn0;
  logic [TRIG_W-1:0]       cs0;

  assign psn = up.x * up.s;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cry0  <= up.cry;
      quad0 <= up.quad;
      swap0 <= up.swap;
      sn0   <= psn[Q +: TRIG_W];
      cs0   <= up.c;
    end
  end

  // stage 1: octant swap, quadrant select, round magnitudes
  logic              sel;
  logic [TRIG_W-1:0] so_mag;
  logic [TRIG_W-1:0] co_mag;
  logic [TRIG_W-1:0] so_rnd;
  logic [TRIG_W-1:0] co_rnd;
  vpr_carry_t        cry1;
  logic [MW-1:0]     smag1;
  logic [MW-1:0]     cmag1;
  logic              sneg1;
  logic              cneg1;

  assign sel    = swap0 ^ quad0[0];
  assign so_mag = sel ? cs0 : sn0;
  assign co_mag = sel ? sn0 : cs0;
  assign so_rnd = so_mag + RHALF;
  assign co_rnd = co_mag + RHALF;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cry1  <= cry0;
      smag1 <= so_rnd[RSH +: MW];
      cmag1 <= co_rnd[RSH +: MW];
      sneg1 <= quad0[1] ^ plane_flip(cry0.plane);
      cneg1 <= quad0[1] ^ quad0[0];
    end
  end

  // stage 2: apply signs
  logic signed [CW-1:0] sm;
  logic signed [CW-1:0] cm;

  assign sm = $signed({1'b0, smag1});
  assign cm = $signed({1'b0, cmag1});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      dn_cry <= cry1;
      dn_sn  <= sneg1 ? -sm : sm;
      dn_cs  <= cneg1 ? -cm : cm;
    end
  end

endmodule

### hdl/vpr_mix.sv
// Rotates the chosen coordinate pair, adds the center back, saturates; holds the result word.
module vpr_mix import vpr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  vpr_point_t                   center,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  vpr_carry_t                   up_cry,
  input  logic signed [FRAC_BITS+1:0]  up_sn,
  input  logic signed [FRAC_BITS+1:0]  up_cs,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output vpr_point_t                   res_pt,
  output logic                         res_clip
);

  localparam int CW = FRAC_BITS + 2;
  localparam int PW = COORD_W + 1 + CW;
  localparam int AW = PW + 1;
  localparam int VW = AW - FRAC_BITS + 1;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic [3:0] v;
  logic [3:0] en;

  assign en[3] = ~v[3] | dn_ready;
  assign en[2] = ~v[2] | en[3];
  assign en[1] = ~v[1] | en[2];
  assign en[0] = ~v[0] | en[1];
  assign up_ready = en[0];
  assign dn_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // stage 0: the four products
  logic signed [COORD_W:0] da_u;
  logic signed [COORD_W:0] db_u;
  logic signed [PW-1:0]    pac_n;
  logic signed [PW-1:0]    pbs_n;
  logic signed [PW-1:0]    pbc_n;
  logic signed [PW-1:0]    pas_n;
  vpr_carry_t              cry0;
  logic signed [PW-1:0]    pac;
  logic signed [PW-1:0]    pbs;
  logic signed [PW-1:0]    pbc;
  logic signed [PW-1:0]    pas;

  assign da_u  = up_cry.da;
  assign db_u  = up_cry.db;
  assign pac_n = da_u * up_cs;
  assign pbs_n = db_u * up_sn;
  assign pbc_n = db_u * up_cs;
  assign pas_n = da_u * up_sn;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cry0 <= up_cry;
      pac  <= pac_n;
      pbs  <= pbs_n;
      pbc  <= pbc_n;
      pas  <= pas_n;
    end
  end

  // stage 1: sums with rounding half
  vpr_carry_t           cry1;
  logic signed [AW-1:0] acc_a;
  logic signed [AW-1:0] acc_b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cry1  <= cry0;
      acc_a <= pac + pbs + HALF;
      acc_b <= pbc - pas + HALF;
    end
  end

  // stage 2: drop fraction, add center back
  logic signed [AW-1:0] sha;
  logic signed [AW-1:0] shb;
  logic [1:0]           lo1;
  logic [1:0]           hi1;
  vpr_carry_t           cry2;
  logic signed [VW-1:0] va;
  logic signed [VW-1:0] vb;

  assign sha = acc_a >>> FRAC_BITS;
  assign shb = acc_b >>> FRAC_BITS;
  assign lo1 = axis_lo(cry1.plane);
  assign hi1 = axis_hi(cry1.plane);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      cry2 <= cry1;
      va   <= $signed(sha[VW-1:0]) + $signed(center[lo1]);
      vb   <= $signed(shb[VW-1:0]) + $signed(center[hi1]);
    end
  end

  // stage 3: saturate and write back into the point (output register)
  logic               ovf_a;
  logic               ovf_b;
  logic [COORD_W-1:0] sat_a;
  logic [COORD_W-1:0] sat_b;
  logic [1:0]         lo2;
  logic [1:0]         hi2;
  vpr_point_t         pt_next;
  logic               clip_next;

  assign ovf_a = (va[VW-1:COORD_W-1] != '0) && (va[VW-1:COORD_W-1] != '1);
  assign ovf_b = (vb[VW-1:COORD_W-1] != '0) && (vb[VW-1:COORD_W-1] != '1);
  assign sat_a = ovf_a ? (va[VW-1] ? COORD_MIN : COORD_MAX) : va[COORD_W-1:0];
  assign sat_b = ovf_b ? (vb[VW-1] ? COORD_MIN : COORD_MAX) : vb[COORD_W-1:0];
  assign lo2   = axis_lo(cry2.plane);
  assign hi2   = axis_hi(cry2.plane);

  always_comb begin
    pt_next   = cry2.pt;
    clip_next = 1'b0;
    if (plane_ok(cry2.plane)) begin
      pt_next[lo2] = sat_a;
      pt_next[hi2] = sat_b;
      clip_next    = ovf_a | ovf_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      res_pt   <= pt_next;
      res_clip <= clip_next;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench of the 4D plane rotation unit: points, register writes, rotated words.
`timescale 1ns / 1ps

module testbench import vpr_pkg::*; ();

  // block parameters under test
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // plane codes with no rotation behind them
  localparam logic [PLANE_W-1:0] PLANE_SPARE_LO = 3'd6;
  localparam logic [PLANE_W-1:0] PLANE_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES  = 40;    // pipe is 25 deep
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any accepted word
  localparam int PHASES         = 8;
  localparam int PHASE_POINTS   = 140;

  // trig core constants, Q30
  localparam longint unsigned TRIG_ONE = 64'd1 << 30;
  localparam longint unsigned HALF_PI  = 64'd1686629713;
  // Horner divisors, element [0] applied first
  localparam logic [4:0][7:0] SIN_STEP = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};
  localparam logic [4:0][7:0] COS_STEP = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90};

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  localparam logic [COORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
    logic [ANGLE_W-1:0] angle;
    logic [PLANE_W-1:0] plane;
  } point_word_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] w;
    logic               clipped;
  } rotated_word_t;

  typedef enum logic [1:0] {WORD_POINT, WORD_REG, WORD_DRAIN} word_kind_t;

  typedef struct {
    word_kind_t           kind;
    point_word_t          pt;
    logic [CFG_IDX_W-1:0] idx;
    logic [COORD_W-1:0]   data;
  } stim_word_t;

  logic clk;
  logic rst;

  vpr_point_if  point_ch ();
  vpr_result_if result_ch ();
  vpr_cfg_if    reg_ch ();

  vec4_plane_rotation_unit #(
    .ANGLE_BITS(ANGLE_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (reg_ch),
    .points (point_ch),
    .rotated(result_ch)
  );

  stim_word_t         pending [$];       // words not yet offered to the block
  rotated_word_t      rotation_due [$];  // rotated words still owed, oldest first
  logic signed [COORD_W-1:0] center_reg [NUM_AXES];  // mirror of the center registers
  int                 errors;
  int                 idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // all block inputs known from time zero, with reset asserted at the start
  initial begin
    rst                 = 1'b1;
    point_ch.valid      = 1'b0;
    point_ch.in_x       = '0;
    point_ch.in_y       = '0;
    point_ch.in_z       = '0;
    point_ch.in_w       = '0;
    point_ch.turn_angle = '0;
    point_ch.plane      = '0;
    result_ch.ready     = 1'b0;
    reg_ch.valid        = 1'b0;
    reg_ch.index        = '0;
    reg_ch.data         = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // sine and cosine in Q30 of f / 2^32 turn, f within the first octant
  function automatic void octant_trig(input longint unsigned f,
                                      output longint unsigned sn,
                                      output longint unsigned cs);
    longint unsigned x, x2, s, c;
    x  = (f * HALF_PI) >> 30;
    x2 = (x * x) >> 30;
    s  = TRIG_ONE;
    c  = TRIG_ONE;
    for (int i = 0; i < 5; i++) begin
      s = TRIG_ONE - ((x2 * s) >> 30) / SIN_STEP[i];
      c = TRIG_ONE - ((x2 * c) >> 30) / COS_STEP[i];
    end
    sn = (x * s) >> 30;
    cs = c;
  endfunction

  // Q30 to Q(FRAC_BITS), rounding on the magnitude
  function automatic longint round_coef(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    return (v < 0) ? -m : m;
  endfunction

  function automatic void turn_coefs(input logic [ANGLE_W-1:0] angle,
                                     output longint sn, output longint cs);
    logic [31:0]     t;
    longint unsigned r, su, cu;
    longint          s, c;
    t = 32'(angle & ((1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
    r = 64'(t[29:0]);
    // second half of each quadrant folds back with sine and cosine swapped
    if (r < (64'd1 << 29)) octant_trig(r, su, cu);
    else                   octant_trig(TRIG_ONE - r, cu, su);
    s = longint'(su);
    c = longint'(cu);
    case (t[31:30])
      2'd0: begin sn = s;  cs = c;  end
      2'd1: begin sn = c;  cs = -s; end
      2'd2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
    sn = round_coef(sn);
    cs = round_coef(cs);
  endfunction

  function automatic longint settle(input longint acc, input longint cen, inout logic clip);
    longint v;
    v = ((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + cen;
    if (v > SAT_HI) begin
      clip = 1'b1;
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      clip = 1'b1;
      return SAT_LO;
    end
    return v;
  endfunction

  function automatic rotated_word_t rotate_point(input point_word_t p);
    longint        crd [NUM_AXES];
    longint        cen [NUM_AXES];
    longint        sn, cs, da, db;
    int            a, b;
    logic          flip, clip;
    rotated_word_t res;
    crd[0] = longint'($signed(p.x));
    crd[1] = longint'($signed(p.y));
    crd[2] = longint'($signed(p.z));
    crd[3] = longint'($signed(p.w));
    for (int i = 0; i < NUM_AXES; i++) cen[i] = longint'(center_reg[i]);
    clip = 1'b0;
    a    = AXIS_X;
    b    = AXIS_Y;
    flip = 1'b0;
    case (p.plane)
      PLANE_XY: begin a = AXIS_X; b = AXIS_Y; flip = 1'b0; end
      PLANE_XZ: begin a = AXIS_X; b = AXIS_Z; flip = 1'b1; end
      PLANE_XW: begin a = AXIS_X; b = AXIS_W; flip = 1'b0; end
      PLANE_YZ: begin a = AXIS_Y; b = AXIS_Z; flip = 1'b0; end
      PLANE_YW: begin a = AXIS_Y; b = AXIS_W; flip = 1'b1; end
      PLANE_ZW: begin a = AXIS_Z; b = AXIS_W; flip = 1'b1; end
      default: ;
    endcase
    if (p.plane <= PLANE_ZW) begin
      turn_coefs(p.angle, sn, cs);
      if (flip) sn = -sn;
      da     = crd[a] - cen[a];
      db     = crd[b] - cen[b];
      crd[a] = settle(da * cs + db * sn, cen[a], clip);
      crd[b] = settle(db * cs - da * sn, cen[b], clip);
    end
    res.x       = crd[0][31:0];
    res.y       = crd[1][31:0];
    res.z       = crd[2][31:0];
    res.w       = crd[3][31:0];
    res.clipped = clip;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones, now and then a burst with none
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // coordinates: full range, small, extremes, or close to the given center
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] near);
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return 32'($urandom_range(0, 262143) - 131072);
      4, 5: return near + 32'($urandom_range(0, 8388607) - 4194304);
      default: return $urandom();
    endcase
  endfunction

  // random angles, with a share on the quadrant and octant edges
  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 4) == 0)
      return 16'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic push_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] w,
                            input logic [ANGLE_W-1:0] angle,
                            input logic [PLANE_W-1:0] plane);
    stim_word_t sw;
    sw.kind     = WORD_POINT;
    sw.pt.x     = x;
    sw.pt.y     = y;
    sw.pt.z     = z;
    sw.pt.w     = w;
    sw.pt.angle = angle;
    sw.pt.plane = plane;
    sw.idx      = '0;
    sw.data     = '0;
    pending.push_back(sw);
  endtask

  task automatic push_control(input word_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                              input logic [COORD_W-1:0] data);
    stim_word_t sw;
    sw.kind = kind;
    sw.pt   = '0;
    sw.idx  = idx;
    sw.data = data;
    pending.push_back(sw);
  endtask

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                             input logic [COORD_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending words in order. Register writes and drain marks
  // hold until every owed rotated word has come back, so the centers only
  // change while the pipe is empty.
  // ---------------------------------------------------------------------------
  int          send_gap;
  int          send_burst;
  stim_word_t  head;
  logic        launch_point, launch_reg;
  point_word_t taken;

  always @(posedge clk) begin
    if (rst) begin
      point_ch.valid <= 1'b0;
      reg_ch.valid   <= 1'b0;
      send_gap   = 0;
      send_burst = 0;
      for (int i = 0; i < NUM_AXES; i++) center_reg[i] = '0;
    end else begin
      // words accepted at this edge
      if (point_ch.valid && point_ch.ready) begin
        taken = {point_ch.in_x, point_ch.in_y, point_ch.in_z, point_ch.in_w,
                 point_ch.turn_angle, point_ch.plane};
        rotation_due.push_back(rotate_point(taken));
      end
      if (reg_ch.valid && reg_ch.ready) center_reg[reg_ch.index] = reg_ch.data;

      // a word still waiting on ready keeps valid and payload as they are
      if (!(point_ch.valid && !point_ch.ready) && !(reg_ch.valid && !reg_ch.ready)) begin
        launch_point = 1'b0;
        launch_reg   = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() != 0) begin
          head = pending[0];
          case (head.kind)
            WORD_POINT: begin
              point_ch.in_x       <= head.pt.x;
              point_ch.in_y       <= head.pt.y;
              point_ch.in_z       <= head.pt.z;
              point_ch.in_w       <= head.pt.w;
              point_ch.turn_angle <= head.pt.angle;
              point_ch.plane      <= head.pt.plane;
              launch_point = 1'b1;
              void'(pending.pop_front());
              send_gap = pick_gap(send_burst);
            end
            WORD_REG: begin
              if (rotation_due.size() == 0) begin
                reg_ch.index <= head.idx;
                reg_ch.data  <= head.data;
                launch_reg = 1'b1;
                void'(pending.pop_front());
                send_gap = pick_gap(send_burst);
              end
            end
            default: begin
              // sender holds off until the pipe has drained
              if (rotation_due.size() == 0) void'(pending.pop_front());
            end
          endcase
        end
        point_ch.valid <= launch_point;
        reg_ch.valid   <= launch_reg;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted rotated word against the oldest one owed,
  // and stalls the output side at random.
  // ---------------------------------------------------------------------------
  int            recv_gap;
  int            recv_burst;
  rotated_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_gap   = 0;
      recv_burst = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (rotation_due.size() == 0) begin
          flag_error("rotated word with none owed");
        end else begin
          want = rotation_due.pop_front();
          check_field("out_x", result_ch.out_x, want.x);
          check_field("out_y", result_ch.out_y, want.y);
          check_field("out_z", result_ch.out_z, want.z);
          check_field("out_w", result_ch.out_w, want.w);
          check_field("clipped", 32'(result_ch.clipped), 32'(want.clipped));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        recv_gap = pick_gap(recv_burst);
      end
    end
  end

  // watchdog: a long stretch with no word moving on any channel is a hang
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] cset [NUM_AXES];
  int                 drain_at;

  initial begin
    errors = 0;

    // directed, centers at their reset value of zero
    // every plane with extreme coordinates at quadrant and octant edges
    push_point(COORD_MAX, COORD_MIN, 32'h0001_8000, 32'hFFFC_C000, 16'd0,     PLANE_XY);
    push_point(COORD_MAX, COORD_MIN, 32'h0001_8000, 32'hFFFC_C000, 16'd16384, PLANE_XZ);
    push_point(COORD_MIN, COORD_MAX, 32'h0001_8000, 32'hFFFC_C000, 16'd32768, PLANE_XW);
    push_point(COORD_MAX, COORD_MIN, COORD_MAX, 32'hFFFC_C000,     16'd49152, PLANE_YZ);
    push_point(ONE_Q16, 32'h0003_0000, COORD_MIN, 32'hFFFF_0000,   16'd8192,  PLANE_YW);
    push_point(ONE_Q16, COORD_MAX, 32'h0000_4000, COORD_MIN,       16'd65535, PLANE_ZW);
    // either side of the octant fold
    push_point(ONE_Q16, ONE_Q16, '0, '0, 16'd8191, PLANE_XY);
    push_point(ONE_Q16, ONE_Q16, '0, '0, 16'd8193, PLANE_XY);
    push_point(32'h0012_3456, 32'hFFED_CBA9, '0, '0, 16'd24576, PLANE_XY);
    // direction of turn on a plain and on a flipped plane
    push_point(ONE_Q16, '0, '0, '0, 16'd16384, PLANE_XY);
    push_point(ONE_Q16, '0, '0, '0, 16'd16384, PLANE_XZ);
    // unused plane codes pass the point through
    push_point(COORD_MAX, COORD_MIN, 32'h1234_5678, 32'h8765_4321, 16'd12345, PLANE_SPARE_LO);
    push_point(COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, PLANE_SPARE_HI);
    // saturation at both ends
    push_point(COORD_MAX, COORD_MAX, '0, '0, 16'd8192, PLANE_XY);
    push_point(COORD_MIN, COORD_MIN, '0, '0, 16'd8192, PLANE_XY);
    push_point('0, '0, COORD_MIN, COORD_MAX, 16'd40960, PLANE_ZW);
    push_point('0, COORD_MAX, '0, COORD_MAX, 16'd57344, PLANE_YW);
    // zero point, alternating angle bits
    push_point('0, '0, '0, '0, 16'd0, PLANE_XY);
    push_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 16'h5555, PLANE_XW);
    push_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 16'hAAAA, PLANE_YZ);

    // random phases, each under its own set of centers
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        case (ph)
          0: cset[i] = (i % 2 == 0) ? COORD_MAX : COORD_MIN;
          1: cset[i] = (i % 2 == 0) ? COORD_MIN : COORD_MAX;
          2: cset[i] = '0;
          default: cset[i] = pick_coord('0);
        endcase
      end
      push_control(WORD_REG, REG_CENTER_X, cset[0]);
      push_control(WORD_REG, REG_CENTER_Y, cset[1]);
      push_control(WORD_REG, REG_CENTER_Z, cset[2]);
      push_control(WORD_REG, REG_CENTER_W, cset[3]);
      drain_at = $urandom_range(20, PHASE_POINTS - 20);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        if (n == drain_at) push_control(WORD_DRAIN, '0, '0);
        push_point(pick_coord(cset[0]), pick_coord(cset[1]),
                   pick_coord(cset[2]), pick_coord(cset[3]), pick_angle(),
                   ($urandom_range(0, 19) == 0) ?
                     PLANE_W'($urandom_range(PLANE_SPARE_LO, PLANE_SPARE_HI)) :
                     PLANE_W'($urandom_range(PLANE_XY, PLANE_ZW)));
      end
    end

    // sampled away from the active edge so the driver's updates have landed
    @(negedge clk);
    while (rst || pending.size() != 0 || point_ch.valid || reg_ch.valid) @(negedge clk);
    while (rotation_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
